[rtl/entity_delta_snapshot_codec_assert.svh]
// Assertion macros for the snapshot delta codec.
// Needs a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef ENTITY_DELTA_SNAPSHOT_CODEC_ASSERT_SVH
`define ENTITY_DELTA_SNAPSHOT_CODEC_ASSERT_SVH

// same-cycle implication
`define EDSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/edsc_pkg.sv]
// Package for the snapshot delta codec: action codes, state enum, entry layout.
// No dependencies.
`default_nettype none

package edsc_pkg;

    localparam int VAL_W      = 32;
    localparam int NVAL       = 7;
    localparam int ID_W       = 8;
    localparam int ACT_W      = 3;
    localparam int IN_DATA_W  = ID_W + VAL_W + NVAL * VAL_W;
    localparam int IN_USER_W  = ACT_W + 1;
    localparam int OUT_DATA_W = ID_W + VAL_W + NVAL * VAL_W;
    localparam int OUT_USER_W = 1;
    localparam logic [VAL_W-1:0] INTERVAL_RST = 32'd30;

    localparam logic [ACT_W-1:0] ACT_ENCODE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DECODE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FORCE_ONE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FORCE_ALL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE    = 3'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } t_state;

    // element 0 is pos_x, then pos_y, pos_z, vel_x, vel_y, vel_z, yaw
    typedef logic [NVAL-1:0][VAL_W-1:0] t_vals;

    typedef struct packed {
        logic             valid;
        logic             frc;
        logic [VAL_W-1:0] key_tick;
        t_vals            vals;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

[rtl/edsc_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none

module edsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/entity_delta_snapshot_codec.sv]
// Snapshot delta codec top level: baseline table in one RAM, read-modify-write control.
// Depends on edsc_pkg, edsc_ram and entity_delta_snapshot_codec_assert.svh.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: item fields, tuser: action, is_keyframe
//  m_axis    out  m_axis_tvalid/tready       tdata: result fields, tuser: out_keyframe
//  cfg       in   i_cfg_we                   i_cfg_wdata: keyframe_interval
//
// Encode, decode, force one, remove: the baseline is read through the one RAM read port
// when the item is accepted, then modified and written back in ST_EXEC.
// Force all: the accept cycle, then a pipelined sweep over the table.
// After reset: the table is cleared entry by entry, no input taken meanwhile.
// A result waiting in the full output register holds the block in its write-back cycle.
`default_nettype none

module entity_delta_snapshot_codec #(
    parameter int ENTITY_COUNT = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [31:0]                   i_cfg_wdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // entity_id, tick, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, yaw
    input  wire logic [edsc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // action, is_keyframe
    input  wire logic [edsc_pkg::IN_USER_W-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // out_entity, out_tick, out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y,
    // out_vel_z, out_yaw
    output logic [edsc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // out_keyframe
    output logic [edsc_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    import edsc_pkg::*;

    localparam int AW = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
    localparam int CW = $clog2(ENTITY_COUNT + 1);
    localparam logic [CW-1:0] CNT_END = CW'(ENTITY_COUNT);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_sw_v, n_sw_v;
    logic [AW-1:0]     r_sw_addr, n_sw_addr;
    logic [VAL_W-1:0]  r_interval;
    logic              r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic              r_out_key;

    logic [ACT_W-1:0]  r_act;
    logic [ID_W-1:0]   r_id;
    logic [AW-1:0]     r_addr;
    logic              r_inrange;
    logic [VAL_W-1:0]  r_tick;
    logic              r_iskey;
    t_vals             r_cur;

    logic              accept;
    logic              sweep_go;
    logic [ACT_W-1:0]  in_act;
    logic [ID_W-1:0]   in_id;
    logic [AW+ID_W-1:0] in_id_ext;
    logic [AW-1:0]     in_addr;
    logic              in_inrange;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic [AW-1:0]     ram_raddr;
    t_entry            ent;

    logic [VAL_W-1:0]  ivl;
    logic              due;
    t_vals             diff, sum;
    logic              has_res, wr_req, out_free, ld_out;
    t_entry            wentry;
    logic              res_key;
    t_vals             res_vals;

    assign in_act     = s_axis_tuser[ACT_W-1:0];
    assign in_id      = s_axis_tdata[ID_W-1:0];
    assign in_id_ext  = {{AW{1'b0}}, in_id};
    assign in_addr    = in_id_ext[AW-1:0];
    assign in_inrange = 32'(in_id) < 32'(ENTITY_COUNT);
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign sweep_go   = accept && (in_act == ACT_FORCE_ALL);

    edsc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTITY_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ent)
    );

    // datapath for the write-back cycle
    always_comb begin
        ivl = (r_interval == '0) ? VAL_W'(1) : r_interval;
        due = !ent.valid || ent.frc || ((r_tick - ent.key_tick) >= ivl);
        for (int i = 0; i < NVAL; i++) begin
            diff[i] = r_cur[i] - ent.vals[i];
            sum[i]  = ent.vals[i] + r_cur[i];
        end

        has_res  = 1'b0;
        wr_req   = 1'b0;
        wentry   = ent;
        res_key  = 1'b1;
        res_vals = r_cur;
        unique case (r_act)
            ACT_ENCODE: begin
                has_res = r_inrange;
                wr_req  = r_inrange;
                if (due) begin
                    wentry = '{valid: 1'b1, frc: 1'b0, key_tick: r_tick, vals: r_cur};
                end else begin
                    wentry   = '{valid: 1'b1, frc: ent.frc, key_tick: ent.key_tick,
                                 vals: r_cur};
                    res_key  = 1'b0;
                    res_vals = diff;
                end
            end
            ACT_DECODE: begin
                if (r_iskey) begin
                    has_res = r_inrange;
                    wentry  = '{valid: 1'b1, frc: ent.valid & ent.frc, key_tick: r_tick,
                                vals: r_cur};
                end else begin
                    has_res  = r_inrange && ent.valid;
                    wentry   = '{valid: 1'b1, frc: ent.frc, key_tick: ent.key_tick,
                                 vals: sum};
                    res_vals = sum;
                end
                wr_req = has_res;
            end
            ACT_FORCE_ONE: begin
                wr_req     = r_inrange && ent.valid;
                wentry.frc = 1'b1;
            end
            ACT_REMOVE: begin
                wr_req       = r_inrange;
                wentry.valid = 1'b0;
                wentry.frc   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign out_free = !r_out_valid || m_axis_tready;

    // next state and table control
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sw_v      = r_sw_v;
        n_sw_addr   = r_sw_addr;
        n_out_valid = r_out_valid && !m_axis_tready;
        s_axis_tready = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = wentry;
        ram_raddr   = r_addr;
        ld_out      = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = '0;
                if (r_cnt == CNT_END) begin
                    n_state = ST_IDLE;
                end else begin
                    ram_we = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                ram_raddr     = in_addr;
                if (accept) begin
                    n_cnt  = '0;
                    n_sw_v = 1'b0;
                    n_state = (in_act == ACT_FORCE_ALL) ? ST_SWEEP : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!has_res || out_free) begin
                    ram_we  = wr_req;
                    ld_out  = has_res;
                    n_state = ST_IDLE;
                    if (has_res) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_SWEEP: begin
                ram_raddr       = r_cnt[AW-1:0];
                ram_we          = r_sw_v;
                ram_waddr       = r_sw_addr;
                ram_wdata       = ent;
                ram_wdata.frc   = ent.frc | ent.valid;
                n_sw_v          = (r_cnt != CNT_END);
                n_sw_addr       = r_cnt[AW-1:0];
                if (r_cnt != CNT_END) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (!r_sw_v) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_sw_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_interval  <= INTERVAL_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sw_v      <= n_sw_v;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw_addr <= n_sw_addr;
        if (accept) begin
            r_act     <= in_act;
            r_id      <= in_id;
            r_addr    <= in_addr;
            r_inrange <= in_inrange;
            r_tick    <= s_axis_tdata[ID_W +: VAL_W];
            r_iskey   <= s_axis_tuser[ACT_W];
            r_cur     <= s_axis_tdata[IN_DATA_W-1:ID_W+VAL_W];
        end
        if (ld_out) begin
            r_out_data <= {res_vals, r_tick, r_id};
            r_out_key  <= res_key;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_key;

`include "entity_delta_snapshot_codec_assert.svh"

    `EDSC_ASSERT_NOW(a_load_free, ld_out, out_free, "result overwrote pending output")
    `EDSC_ASSERT_NEXT(a_sweep_start, sweep_go, r_state == ST_SWEEP && r_cnt == '0, "no sweep")
    `EDSC_ASSERT_NOW(a_exec_addr, r_state == ST_EXEC && ram_we, ram_waddr == r_addr, "wrong entry")
    `EDSC_ASSERT_NOW(a_clear_zero, r_state == ST_CLEAR && ram_we, ram_wdata == '0, "clear nonzero")
    `EDSC_ASSERT_NOW(a_no_take_busy, r_state != ST_IDLE, !s_axis_tready, "input taken outside idle")
    `EDSC_ASSERT_NOW(a_load_exec, ld_out, r_state == ST_EXEC, "load outside write-back")

endmodule

`default_nettype wire
